// File: sv/ptt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ptt_pkg;

  localparam int MAX_TASKS_DEF = 16;
  localparam int RESULT_LIMIT  = 16;
  localparam int NREP_W        = $clog2(RESULT_LIMIT + 1);
  localparam int ID_W          = 5;

  // Item function codes
  localparam logic [2:0] FN_TICK   = 3'd0;
  localparam logic [2:0] FN_SCAN   = 3'd1;
  localparam logic [2:0] FN_START  = 3'd2;
  localparam logic [2:0] FN_HALT   = 3'd3;
  localparam logic [2:0] FN_RESUME = 3'd4;
  localparam logic [2:0] FN_SETP   = 3'd5;

  // Result kinds
  localparam logic [2:0] K_DUE      = 3'd0;
  localparam logic [2:0] K_NONE     = 3'd1;
  localparam logic [2:0] K_DONE     = 3'd2;
  localparam logic [2:0] K_NOTFOUND = 3'd3;
  localparam logic [2:0] K_FULL     = 3'd4;

  // Source of the pending result identifier
  localparam logic [1:0] ID_ZERO = 2'd0;
  localparam logic [1:0] ID_NEW  = 2'd1;
  localparam logic [1:0] ID_CMD  = 2'd2;
  localparam logic [1:0] ID_ROW  = 2'd3;

  typedef struct packed {
    logic [31:0]     start;
    logic [31:0]     period;
    logic            halted;
    logic [ID_W-1:0] ident;
  } row_t;

  typedef struct packed {
    logic       accept;
    logic       tick_inc;
    logic       add_entry;
    logic       walk_start;
    logic       advance;
    logic       wr_restart;
    logic       wr_find;
    logic       nrep_inc;
    logic       pend_load;
    logic [2:0] pend_kind;
    logic [1:0] pend_id_sel;
    logic       push_mid;
    logic       push_final;
  } cmd_t;

  typedef struct packed {
    logic out_space;
    logic empty;
    logic full;
    logic due;
    logic halted;
    logic nrep_ok;
    logic pend_valid;
    logic at_last;
    logic match;
  } stat_t;

endpackage

`default_nettype wire

// File: sv/ptt_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ptt_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [7:0]  task_id;
  logic [31:0] period;

  modport source (output valid, func, task_id, period, input ready);
  modport sink   (input valid, func, task_id, period, output ready);
endinterface

interface ptt_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] task_id_out;
  logic       last;

  modport source (output valid, kind, task_id_out, last, input ready);
  modport sink   (input valid, kind, task_id_out, last, output ready);
endinterface

`default_nettype wire

// File: sv/ptt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module ptt_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic [2:0]    in_func,
  output logic               in_ready,
  input  wire ptt_pkg::stat_t st,
  output ptt_pkg::cmd_t      cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIND = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       report;
  logic       stall;

  assign in_ready = (state_r == S_IDLE);

  // A due, running entry becomes a report while the result budget lasts
  assign report = st.due && !st.halted && st.nrep_ok;
  // A held report has to leave before a new one can take its place
  assign stall  = report && st.pend_valid && !st.out_space;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          unique case (in_func) inside
            ptt_pkg::FN_TICK: begin
              cmd.tick_inc    = 1'b1;
              cmd.pend_load   = 1'b1;
              cmd.pend_kind   = ptt_pkg::K_DONE;
              cmd.pend_id_sel = ptt_pkg::ID_ZERO;
              state_nxt       = S_EMIT;
            end
            ptt_pkg::FN_SCAN: begin
              cmd.walk_start = 1'b1;
              state_nxt      = st.empty ? S_EMIT : S_SCAN;
            end
            ptt_pkg::FN_START: begin
              cmd.pend_load = 1'b1;
              if (st.full) begin
                cmd.pend_kind   = ptt_pkg::K_FULL;
                cmd.pend_id_sel = ptt_pkg::ID_ZERO;
              end else begin
                cmd.add_entry   = 1'b1;
                cmd.pend_kind   = ptt_pkg::K_DONE;
                cmd.pend_id_sel = ptt_pkg::ID_NEW;
              end
              state_nxt = S_EMIT;
            end
            ptt_pkg::FN_HALT, ptt_pkg::FN_RESUME, ptt_pkg::FN_SETP: begin
              cmd.walk_start = 1'b1;
              if (st.empty) begin
                cmd.pend_load   = 1'b1;
                cmd.pend_kind   = ptt_pkg::K_NOTFOUND;
                cmd.pend_id_sel = ptt_pkg::ID_ZERO;
                state_nxt       = S_EMIT;
              end else begin
                state_nxt = S_FIND;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (!stall) begin
          cmd.push_mid   = report && st.pend_valid;
          cmd.wr_restart = st.due;
          cmd.advance    = 1'b1;
          if (report) begin
            cmd.nrep_inc    = 1'b1;
            cmd.pend_load   = 1'b1;
            cmd.pend_kind   = ptt_pkg::K_DUE;
            cmd.pend_id_sel = ptt_pkg::ID_ROW;
          end
          if (st.at_last) begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_FIND: begin
        if (st.match) begin
          cmd.wr_find     = 1'b1;
          cmd.pend_load   = 1'b1;
          cmd.pend_kind   = ptt_pkg::K_DONE;
          cmd.pend_id_sel = ptt_pkg::ID_CMD;
          state_nxt       = S_EMIT;
        end else if (st.at_last) begin
          cmd.pend_load   = 1'b1;
          cmd.pend_kind   = ptt_pkg::K_NOTFOUND;
          cmd.pend_id_sel = ptt_pkg::ID_ZERO;
          state_nxt       = S_EMIT;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      S_EMIT: begin
        if (st.out_space) begin
          cmd.push_final = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/ptt_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module ptt_dp #(
  parameter int MAX_TASKS = ptt_pkg::MAX_TASKS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire ptt_pkg::cmd_t cmd,
  output ptt_pkg::stat_t     st,
  input  wire logic [7:0]    in_task_id,
  input  wire logic [2:0]    in_func,
  input  wire logic [31:0]   in_period,
  input  wire logic          out_ready,
  output logic               out_valid,
  output logic [2:0]         out_kind,
  output logic [7:0]         out_task_id,
  output logic               out_last
);

  localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int NW = ptt_pkg::NREP_W;
  localparam int IDW = ptt_pkg::ID_W;

  ptt_pkg::row_t mem [MAX_TASKS];
  ptt_pkg::row_t rd_row_r;
  ptt_pkg::row_t wr_row;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [IW-1:0] rd_addr;

  logic [31:0]    tick_r;
  logic [IDW-1:0] next_id_r;
  logic [CW-1:0]  count_r;
  logic [IW-1:0]  idx_r;
  logic [NW-1:0]  nrep_r;
  logic [2:0]     cmd_func_r;
  logic [7:0]     cmd_id_r;
  logic [31:0]    cmd_period_r;
  logic           pend_valid_r;
  logic [2:0]     pend_kind_r;
  logic [7:0]     pend_id_r;
  logic [7:0]     pend_id_nxt;
  logic           out_valid_r;
  logic [2:0]     out_kind_r;
  logic [7:0]     out_id_r;
  logic           out_last_r;
  logic           out_space;
  logic [31:0]    elapsed;

  assign out_space = !out_valid_r || out_ready;
  assign elapsed   = tick_r - rd_row_r.start;

  assign st.out_space  = out_space;
  assign st.empty      = (count_r == '0);
  assign st.full       = (count_r == CW'(MAX_TASKS));
  assign st.due        = (elapsed > rd_row_r.period);
  assign st.halted     = rd_row_r.halted;
  assign st.nrep_ok    = (nrep_r < NW'(ptt_pkg::RESULT_LIMIT));
  assign st.pend_valid = pend_valid_r;
  assign st.at_last    = (CW'(idx_r) == count_r - 1'b1);
  assign st.match      = ({3'b000, rd_row_r.ident} == cmd_id_r);

  // Table write port
  always_comb begin
    wr_en   = cmd.add_entry || cmd.wr_restart || cmd.wr_find;
    wr_addr = cmd.add_entry ? count_r[IW-1:0] : idx_r;
    wr_row  = rd_row_r;
    if (cmd.add_entry) begin
      wr_row.start  = tick_r;
      wr_row.period = in_period;
      wr_row.halted = 1'b0;
      wr_row.ident  = next_id_r;
    end else if (cmd.wr_restart) begin
      wr_row.start = tick_r;
    end else begin
      case (cmd_func_r)
        ptt_pkg::FN_HALT:   wr_row.halted = 1'b1;
        ptt_pkg::FN_RESUME: wr_row.halted = 1'b0;
        ptt_pkg::FN_SETP: begin
          wr_row.period = cmd_period_r;
          wr_row.start  = tick_r;
        end
        default: wr_row = rd_row_r;
      endcase
    end
  end

  // Read the entry that the walk looks at next
  always_comb begin
    if (cmd.walk_start) begin
      rd_addr = '0;
    end else if (cmd.advance) begin
      rd_addr = IW'(idx_r + 1'b1);
    end else begin
      rd_addr = idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    rd_row_r <= mem[rd_addr];
  end

  always_comb begin
    case (cmd.pend_id_sel)
      ptt_pkg::ID_NEW: pend_id_nxt = {3'b000, next_id_r};
      ptt_pkg::ID_CMD: pend_id_nxt = cmd_id_r;
      ptt_pkg::ID_ROW: pend_id_nxt = {3'b000, rd_row_r.ident};
      default:         pend_id_nxt = '0;
    endcase
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_func_r   <= in_func;
      cmd_id_r     <= in_task_id;
      cmd_period_r <= in_period;
    end
    if (cmd.walk_start) begin
      idx_r <= '0;
    end else if (cmd.advance) begin
      idx_r <= IW'(idx_r + 1'b1);
    end
    if (cmd.pend_load) begin
      pend_kind_r <= cmd.pend_kind;
      pend_id_r   <= pend_id_nxt;
    end
    if (cmd.push_mid) begin
      out_kind_r <= pend_kind_r;
      out_id_r   <= pend_id_r;
      out_last_r <= 1'b0;
    end else if (cmd.push_final) begin
      out_kind_r <= pend_valid_r ? pend_kind_r : ptt_pkg::K_NONE;
      out_id_r   <= pend_valid_r ? pend_id_r : 8'd0;
      out_last_r <= 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r       <= '0;
      next_id_r    <= IDW'(1);
      count_r      <= '0;
      nrep_r       <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.tick_inc) begin
        tick_r <= tick_r + 32'd1;
      end
      if (cmd.add_entry) begin
        count_r   <= count_r + 1'b1;
        next_id_r <= next_id_r + 1'b1;
      end
      if (cmd.walk_start) begin
        nrep_r <= '0;
      end else if (cmd.nrep_inc) begin
        nrep_r <= nrep_r + 1'b1;
      end
      if (cmd.pend_load) begin
        pend_valid_r <= 1'b1;
      end else if (cmd.push_final) begin
        pend_valid_r <= 1'b0;
      end
      if (cmd.push_mid || cmd.push_final) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_kind    = out_kind_r;
  assign out_task_id = out_id_r;
  assign out_last    = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_TASKS))
    else $error("entry count beyond table size");

  a_nrep_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nrep_r <= NW'(ptt_pkg::RESULT_LIMIT))
    else $error("scan reported beyond result limit");

  a_push_space: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push_mid || cmd.push_final) |-> out_space)
    else $error("result pushed over an untaken word");

  a_add_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.add_entry |=> (count_r == $past(count_r) + 1'b1) && (count_r <= CW'(MAX_TASKS)))
    else $error("entry added to a full table");

endmodule

`default_nettype wire

// File: sv/periodic_task_timer_table.sv
`timescale 1ns / 1ps
`default_nettype none

// Periodic task timer table. Keeps up to MAX_TASKS task entries and a
// 32-bit tick count that advances by one on each tick word. Each input
// word carries a function code: tick, scan, start, halt, resume or set
// period; codes 6 and 7 are dropped without a result. Every other word
// yields one result word, except a scan, which yields one "task due" word
// per due, running entry in table order (at most 16), or a single "nothing
// due" word; the final word of each item has last set. Task entries live
// in a single table memory with one write and one registered read port;
// scan, halt, resume and set period walk it one entry per cycle through
// that read port, a scan pausing while a held report cannot leave. A
// result register on the output lets the next word be taken while the last
// result is still waiting. The table needs no clearing pass after reset:
// only entries below the entry count are ever used.
module periodic_task_timer_table #(
  parameter int MAX_TASKS = ptt_pkg::MAX_TASKS_DEF
) (
  input wire logic   clk,
  input wire logic   rst_n,
  ptt_in_if.sink     in_ch,
  ptt_out_if.source  out_ch
);

  ptt_pkg::cmd_t  cmd;
  ptt_pkg::stat_t st;

  // Sequencer: decode the word, walk the table, hand results out
  ptt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_func  (in_ch.func),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  // Tick count, identifier counter, table memory and result register
  ptt_dp #(
    .MAX_TASKS (MAX_TASKS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .st          (st),
    .in_task_id  (in_ch.task_id),
    .in_func     (in_ch.func),
    .in_period   (in_ch.period),
    .out_ready   (out_ch.ready),
    .out_valid   (out_ch.valid),
    .out_kind    (out_ch.kind),
    .out_task_id (out_ch.task_id_out),
    .out_last    (out_ch.last)
  );

endmodule

`default_nettype wire

// File: bench/tb_periodic_task_timer_table.sv
`timescale 1ns / 1ps

module tb_periodic_task_timer_table;

  localparam int TASK_SLOTS    = ptt_pkg::MAX_TASKS_DEF;
  localparam int ID_BITS       = ptt_pkg::ID_W;
  localparam int RANDOM_WORDS  = 430;
  localparam int HOLD_CYCLES   = 300;
  // A scan walks every table entry; allow well over a full walk before
  // calling the block quiet.
  localparam int SETTLE_CYCLES = 64;
  localparam int STALL_LIMIT   = 2000;

  // Codes 6 and 7 are not commands; the block must drop them silently.
  localparam logic [2:0] FN_UNUSED_LO = 3'd6;
  localparam logic [2:0] FN_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] ident;
    logic       last;
  } report_t;

  logic clk;
  logic rst_n;

  ptt_in_if  in_ch();
  ptt_out_if out_ch();

  periodic_task_timer_table #(.MAX_TASKS(TASK_SLOTS)) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Shadow copy of the task table and tick counter.
  logic [31:0]        ticks;
  logic [ID_BITS-1:0] next_ident;
  int                 rows;
  logic [31:0]        started_at [TASK_SLOTS];
  logic [31:0]        period_of  [TASK_SLOTS];
  logic               halted     [TASK_SLOTS];
  logic [ID_BITS-1:0] ident_of   [TASK_SLOTS];

  // Result words the block still owes, oldest first.
  report_t reports_owed[$];
  report_t head;

  // Run bookkeeping.
  int  failures     = 0;
  int  words_sent   = 0;
  int  results_seen = 0;
  int  due_seen     = 0;
  int  full_seen    = 0;
  int  quiet_cycles = 0;
  int  hold_request = 0;
  bit  rush         = 1'b0;
  bit  offering     = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Table predictor
  // ---------------------------------------------------------------------

  function automatic void owe(input logic [2:0] kind, input logic [7:0] ident,
                              input logic last);
    report_t r;
    r.kind  = kind;
    r.ident = ident;
    r.last  = last;
    reports_owed.push_back(r);
  endfunction

  // Apply one accepted command word to the shadow table and queue the
  // result words it must produce.
  function automatic void table_step(input logic [2:0] func, input logic [7:0] id,
                                     input logic [31:0] period);
    report_t     held;
    bit          holding;
    int          reported;
    int          found;
    logic [31:0] elapsed;
    holding  = 1'b0;
    reported = 0;
    found    = -1;
    case (func)
      ptt_pkg::FN_TICK: begin
        ticks = ticks + 32'd1;
        owe(ptt_pkg::K_DONE, 8'd0, 1'b1);
      end
      ptt_pkg::FN_SCAN: begin
        for (int i = 0; i < rows; i++) begin
          // Elapsed time wraps modulo 2^32; due only when strictly past the period.
          elapsed = ticks - started_at[i];
          if (elapsed > period_of[i]) begin
            if (!halted[i] && reported < ptt_pkg::RESULT_LIMIT) begin
              // Hold each due report back one step so the final one can carry last.
              if (holding) reports_owed.push_back(held);
              held.kind  = ptt_pkg::K_DUE;
              held.ident = {3'b000, ident_of[i]};
              held.last  = 1'b0;
              holding    = 1'b1;
              reported++;
            end
            // Halted or not, a due entry restarts its timer.
            started_at[i] = ticks;
          end
        end
        if (holding) begin
          held.last = 1'b1;
          reports_owed.push_back(held);
        end else begin
          owe(ptt_pkg::K_NONE, 8'd0, 1'b1);
        end
      end
      ptt_pkg::FN_START: begin
        if (rows >= TASK_SLOTS) begin
          owe(ptt_pkg::K_FULL, 8'd0, 1'b1);
        end else begin
          ident_of[rows]   = next_ident;
          halted[rows]     = 1'b0;
          started_at[rows] = ticks;
          period_of[rows]  = period;
          owe(ptt_pkg::K_DONE, {3'b000, next_ident}, 1'b1);
          next_ident = next_ident + 1'b1;
          rows++;
        end
      end
      ptt_pkg::FN_HALT, ptt_pkg::FN_RESUME, ptt_pkg::FN_SETP: begin
        // First match in table order wins; all 8 bits of the id take part.
        for (int i = 0; i < rows && found < 0; i++) begin
          if ({3'b000, ident_of[i]} == id) found = i;
        end
        if (found < 0) begin
          owe(ptt_pkg::K_NOTFOUND, 8'd0, 1'b1);
        end else begin
          case (func)
            ptt_pkg::FN_HALT:   halted[found] = 1'b1;
            ptt_pkg::FN_RESUME: halted[found] = 1'b0;
            default: begin
              period_of[found]  = period;
              started_at[found] = ticks;
            end
          endcase
          owe(ptt_pkg::K_DONE, id, 1'b1);
        end
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Command side
  // ---------------------------------------------------------------------

  // Offer one command word, wait for the handshake, predict, then idle for
  // a random gap. With a zero gap, valid stays high so the next call can
  // follow back to back in the same time step.
  task automatic send_word(input logic [2:0] func, input logic [7:0] id,
                           input logic [31:0] period);
    int gap;
    in_ch.valid   <= 1'b1;
    in_ch.func    <= func;
    in_ch.task_id <= id;
    in_ch.period  <= period;
    offering = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    table_step(func, id, period);
    words_sent++;
    gap = rush ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      offering = 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid if it was left high by a back-to-back send.
  task automatic pause_input();
    if (offering) begin
      in_ch.valid <= 1'b0;
      offering = 1'b0;
      @(posedge clk);
    end
  endtask

  // Hold off new commands until every owed result has arrived.
  task automatic drain_reports();
    pause_input();
    while (reports_owed.size() != 0) @(posedge clk);
  endtask

  // Mostly short periods so entries come due often; sometimes full-width
  // values and the extremes.
  function automatic logic [31:0] pick_period();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(0, 8);
    if (roll < 85) return $urandom();
    case ($urandom_range(0, 2))
      0:       return 32'hFFFF_FFFF;
      1:       return 32'h8000_0000;
      default: return 32'd0;
    endcase
  endfunction

  // Mostly an id that lives in the table; otherwise any 8-bit value.
  function automatic logic [7:0] pick_task_id();
    if (rows > 0 && $urandom_range(0, 4) != 0)
      return {3'b000, ident_of[$urandom_range(0, rows - 1)]};
    return 8'($urandom_range(0, 255));
  endfunction

  // Send one random command; counted is low for the dropped codes.
  task automatic send_random_word(output bit counted);
    int         roll;
    logic [2:0] func;
    roll = $urandom_range(0, 99);
    if      (roll < 35) func = ptt_pkg::FN_TICK;
    else if (roll < 55) func = ptt_pkg::FN_SCAN;
    else if (roll < 65) func = ptt_pkg::FN_START;
    else if (roll < 74) func = ptt_pkg::FN_HALT;
    else if (roll < 83) func = ptt_pkg::FN_RESUME;
    else if (roll < 95) func = ptt_pkg::FN_SETP;
    else                func = $urandom_range(0, 1) ? FN_UNUSED_LO : FN_UNUSED_HI;
    send_word(func, pick_task_id(), pick_period());
    counted = (func <= ptt_pkg::FN_SETP);
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Scan, halt, resume and set period against an empty table, plus the dropped codes.
  task automatic test_empty_table();
    send_word(ptt_pkg::FN_SCAN,   8'd0,   32'd0);
    send_word(ptt_pkg::FN_HALT,   8'd1,   32'd0);
    send_word(ptt_pkg::FN_RESUME, 8'd1,   32'd0);
    send_word(ptt_pkg::FN_SETP,   8'd1,   32'd5);
    send_word(FN_UNUSED_LO,       8'hFF,  32'hFFFF_FFFF);
    send_word(FN_UNUSED_HI,       8'h00,  32'h0000_0000);
  endtask

  // Start, due detection, halt suppressing a report while still restarting
  // the timer, resume, set period restarting the timer, and id lookups that
  // must miss.
  task automatic test_basic_commands();
    send_word(ptt_pkg::FN_START,  8'd0,   32'd0);
    send_word(ptt_pkg::FN_START,  8'hFF,  32'hFFFF_FFFF);
    send_word(ptt_pkg::FN_START,  8'd0,   32'd2);
    send_word(ptt_pkg::FN_TICK,   8'd0,   32'd0);
    send_word(ptt_pkg::FN_TICK,   8'd0,   32'd0);
    send_word(ptt_pkg::FN_SCAN,   8'd0,   32'd0);
    send_word(ptt_pkg::FN_HALT,   8'd1,   32'd0);
    send_word(ptt_pkg::FN_TICK,   8'd0,   32'd0);
    send_word(ptt_pkg::FN_SCAN,   8'd0,   32'd0);
    send_word(ptt_pkg::FN_RESUME, 8'd1,   32'd0);
    send_word(ptt_pkg::FN_SETP,   8'd2,   32'd0);
    send_word(ptt_pkg::FN_TICK,   8'd0,   32'd0);
    send_word(ptt_pkg::FN_SCAN,   8'd0,   32'd0);
    // Low five bits match entry 1, but the full byte must not.
    send_word(ptt_pkg::FN_HALT,   8'h21,  32'd0);
    send_word(ptt_pkg::FN_RESUME, 8'hFF,  32'd0);
    send_word(ptt_pkg::FN_SETP,   8'd0,   32'hFFFF_FFFF);
  endtask

  // Random command mix, with one stretch where neither side idles.
  task automatic test_random_traffic();
    int done_words;
    bit counted;
    done_words = 0;
    while (done_words < RANDOM_WORDS) begin
      rush = (done_words >= 150 && done_words < 210);
      send_random_word(counted);
      if (counted) done_words++;
    end
    rush = 1'b0;
  endtask

  // Fill the table, refuse one more start, then make every entry due while
  // the result side holds off so the block backs up into its input.
  task automatic test_receiver_hold();
    while (rows < TASK_SLOTS) send_word(ptt_pkg::FN_START, 8'd0, 32'd0);
    send_word(ptt_pkg::FN_START, 8'hFF, 32'hFFFF_FFFF);
    hold_request = HOLD_CYCLES;
    for (int i = 0; i < TASK_SLOTS; i++) begin
      send_word(ptt_pkg::FN_RESUME, {3'b000, ident_of[i]}, 32'd0);
      send_word(ptt_pkg::FN_SETP,   {3'b000, ident_of[i]}, 32'd0);
    end
    send_word(ptt_pkg::FN_TICK, 8'd0, 32'd0);
    send_word(ptt_pkg::FN_SCAN, 8'd0, 32'd0);
    // Nothing has elapsed since the restart, so this one finds nothing.
    send_word(ptt_pkg::FN_SCAN, 8'd0, 32'd0);
  endtask

  // Let the block run dry, then pick up random traffic from idle.
  task automatic test_sender_pause();
    bit counted;
    drain_reports();
    for (int n = 0; n < 30; n++) send_random_word(counted);
    drain_reports();
    send_word(ptt_pkg::FN_TICK, 8'd0, 32'd0);
    send_word(ptt_pkg::FN_SCAN, 8'd0, 32'd0);
  endtask

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------

  initial begin
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.func    <= ptt_pkg::FN_TICK;
    in_ch.task_id <= 8'd0;
    in_ch.period  <= 32'd0;
    ticks      = 32'd0;
    next_ident = ID_BITS'(1);
    rows       = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_basic_commands();
    test_random_traffic();
    test_receiver_hold();
    test_sender_pause();

    // Wait out the owed results, then watch for stray words.
    drain_reports();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d command words and %0d result words, %0d of them due reports;",
             words_sent, results_seen, due_seen);
    $display("table filled to %0d entries, %0d start words refused while full.",
             rows, full_seen);
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // ---------------------------------------------------------------------
  // Result side: random backpressure, with one long hold
  // ---------------------------------------------------------------------

  initial begin : result_sink
    int stall;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = rush ? 0 : $urandom_range(0, 11);
      // Fold in a pending long hold and count it down here.
      stall += hold_request;
      hold_request = 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Compare each accepted result word against the oldest owed one.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (out_ch.kind == ptt_pkg::K_DUE)  due_seen++;
      if (out_ch.kind == ptt_pkg::K_FULL) full_seen++;
      if (reports_owed.size() == 0) begin
        $error("unexpected result word: kind %0d task_id_out %0d last %0d",
               out_ch.kind, out_ch.task_id_out, out_ch.last);
        failures++;
      end else begin
        head = reports_owed.pop_front();
        if (out_ch.kind !== head.kind) begin
          $error("kind: expected %0d, got %0d", head.kind, out_ch.kind);
          failures++;
        end
        if (out_ch.task_id_out !== head.ident) begin
          $error("task_id_out: expected %0d, got %0d", head.ident, out_ch.task_id_out);
          failures++;
        end
        if (out_ch.last !== head.last) begin
          $error("last: expected %0d, got %0d", head.last, out_ch.last);
          failures++;
        end
      end
    end
  end

  // Abort when neither side has moved a word for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (rst_n) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: %0d result words still owed", reports_owed.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

endmodule
